>>> design/bq_pkg.sv
// ----------------------------------------------------------------------------
// Biquad package
// Widths, register indexes and the command word that the controller sends
// to the datapath of the transposed direct form II biquad section.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int COEF_BITS    = 24;
	localparam int DELAY_BITS   = SAMPLE_BITS + COEF_BITS;
	localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
	localparam int OUT_SHIFT    = COEF_BITS - 4;
	localparam int ACC_BITS     = 64;
	localparam int SUM_BITS     = ACC_BITS + 2;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_FF_COEF0 = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_FF_COEF1 = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_FF_COEF2 = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_FB_COEF1 = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] REG_FB_COEF2 = CFG_IDX_BITS'(4);

	typedef struct packed {
		logic signed [COEF_BITS-1:0] ff0;
		logic signed [COEF_BITS-1:0] ff1;
		logic signed [COEF_BITS-1:0] ff2;
		logic signed [COEF_BITS-1:0] fb1;
		logic signed [COEF_BITS-1:0] fb2;
	} coef_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_IN_FF0,
		MUL_X_FF1,
		MUL_Y_FB1,
		MUL_X_FF2,
		MUL_Y_FB2
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_PROD_D1,
		ACC_ROUND,
		ACC_PROD_D2,
		ACC_SUB_PROD,
		ACC_LOAD_PROD
	} acc_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     load_x;
		logic     load_y;
		logic     wr_d1;
		logic     wr_d2;
	} cmd_t;

endpackage

>>> design/bq_coef_regs.sv
// ----------------------------------------------------------------------------
// Biquad coefficient registers
// Five signed coefficients written through a plain write port.
// ----------------------------------------------------------------------------
module bq_coef_regs import bq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COEF_BITS-1:0]    cfg_data,
	output coef_t                   coef
);

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FF_COEF0: coef_q.ff0 <= cfg_data;
				REG_FF_COEF1: coef_q.ff1 <= cfg_data;
				REG_FF_COEF2: coef_q.ff2 <= cfg_data;
				REG_FB_COEF1: coef_q.fb1 <= cfg_data;
				REG_FB_COEF2: coef_q.fb2 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

>>> design/bq_datapath.sv
// ----------------------------------------------------------------------------
// Biquad datapath
// One shared multiplier, one saturating accumulator and the two delay
// registers, driven step by step by the controller's command word.
// ----------------------------------------------------------------------------
module bq_datapath import bq_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  coef_t                         coef,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [DELAY_BITS-1:0]  d1_q;
	logic signed [DELAY_BITS-1:0]  d2_q;

	logic signed [SAMPLE_BITS-1:0] mul_a;
	logic signed [COEF_BITS-1:0]   mul_b;
	logic signed [PROD_BITS-1:0]   mul_p;
	logic signed [SUM_BITS-1:0]    prod_ext;
	logic signed [SUM_BITS-1:0]    op_a;
	logic signed [SUM_BITS-1:0]    op_b;
	logic signed [SUM_BITS-1:0]    sum;
	logic signed [ACC_BITS-1:0]    acc_sat;
	logic signed [SAMPLE_BITS-1:0] y_next;
	logic [ACC_BITS-SAMPLE_BITS-OUT_SHIFT:0] y_hi;

	localparam logic signed [SUM_BITS-1:0] HALF_LSB = SUM_BITS'(1) << (OUT_SHIFT - 1);

	// Saturate the wide sum to the 64-bit accumulator range.
	function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [SUM_BITS-1:0] v);
		logic [SUM_BITS-ACC_BITS:0] top;
		top = v[SUM_BITS-1:ACC_BITS-1];
		if (&top || ~|top)
			return v[ACC_BITS-1:0];
		return {v[SUM_BITS-1], {(ACC_BITS-1){~v[SUM_BITS-1]}}};
	endfunction

	// Clamp an accumulator value to the delay register range.
	function automatic logic signed [DELAY_BITS-1:0] clamp_delay(
		input logic signed [ACC_BITS-1:0] v);
		logic [ACC_BITS-DELAY_BITS:0] top;
		top = v[ACC_BITS-1:DELAY_BITS-1];
		if (&top || ~|top)
			return v[DELAY_BITS-1:0];
		return {v[ACC_BITS-1], {(DELAY_BITS-1){~v[ACC_BITS-1]}}};
	endfunction

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MUL_IN_FF0: begin mul_a = sample_in; mul_b = coef.ff0; end
			MUL_X_FF1:  begin mul_a = x_q;       mul_b = coef.ff1; end
			MUL_Y_FB1:  begin mul_a = y_q;       mul_b = coef.fb1; end
			MUL_X_FF2:  begin mul_a = x_q;       mul_b = coef.ff2; end
			MUL_Y_FB2:  begin mul_a = y_q;       mul_b = coef.fb2; end
			default: ;
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_ext = {{(SUM_BITS-PROD_BITS){prod_q[PROD_BITS-1]}}, prod_q};

	always_comb begin
		op_a = {{(SUM_BITS-ACC_BITS){acc_q[ACC_BITS-1]}}, acc_q};
		op_b = '0;
		unique case (cmd.acc_op)
			ACC_PROD_D1: begin
				op_a = prod_ext;
				op_b = {{(SUM_BITS-DELAY_BITS){d1_q[DELAY_BITS-1]}}, d1_q};
			end
			ACC_ROUND:    op_b = HALF_LSB;
			ACC_PROD_D2: begin
				op_a = prod_ext;
				op_b = {{(SUM_BITS-DELAY_BITS){d2_q[DELAY_BITS-1]}}, d2_q};
			end
			ACC_SUB_PROD: op_b = SUM_BITS'(0) - prod_ext;
			ACC_LOAD_PROD: begin
				op_a = prod_ext;
			end
			default: ;
		endcase
	end

	assign sum     = op_a + op_b;
	assign acc_sat = sat_acc(sum);

	// Floor shift of the rounded accumulator, then clamp to the sample range.
	assign y_hi = acc_q[ACC_BITS-1:SAMPLE_BITS-1+OUT_SHIFT];
	assign y_next = (&y_hi || ~|y_hi) ? acc_q[SAMPLE_BITS-1+OUT_SHIFT:OUT_SHIFT]
		: {acc_q[ACC_BITS-1], {(SAMPLE_BITS-1){~acc_q[ACC_BITS-1]}}};

	always_ff @(posedge clk) begin
		if (cmd.load_x)
			x_q <= sample_in;
		if (cmd.load_y)
			y_q <= y_next;
		if (cmd.mul_sel != MUL_NONE)
			prod_q <= mul_p;
		if (cmd.acc_op != ACC_HOLD)
			acc_q <= acc_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			if (cmd.wr_d1)
				d1_q <= clamp_delay(acc_q);
			if (cmd.wr_d2)
				d2_q <= clamp_delay(acc_sat);
		end
	end

	assign sample_out = y_q;

endmodule

>>> design/bq_ctrl.sv
// ----------------------------------------------------------------------------
// Biquad controller
// Steps one sample through the shared multiplier and accumulator and owns
// both handshakes.
// ----------------------------------------------------------------------------
module bq_ctrl import bq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic x_valid,
	output logic x_ready,
	output logic y_valid,
	input  logic y_ready,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_ADD_D1  = 8'b0000_0010,
		ST_ADD_RND = 8'b0000_0100,
		ST_OUT_Y   = 8'b0000_1000,
		ST_ADD_D2  = 8'b0001_0000,
		ST_SUB_FB1 = 8'b0010_0000,
		ST_SAVE_N1 = 8'b0100_0000,
		ST_SUB_FB2 = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   y_valid_q;
	logic   out_free;

	assign out_free = !y_valid_q || y_ready;
	assign x_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_NONE;
		cmd.acc_op  = ACC_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (x_valid) begin
					cmd.mul_sel = MUL_IN_FF0;
					cmd.load_x  = 1'b1;
					state_d     = ST_ADD_D1;
				end
			end
			ST_ADD_D1: begin
				cmd.acc_op = ACC_PROD_D1;
				state_d    = ST_ADD_RND;
			end
			ST_ADD_RND: begin
				cmd.acc_op = ACC_ROUND;
				state_d    = ST_OUT_Y;
			end
			ST_OUT_Y: begin
				// The output register doubles as the y operand, so it may only
				// be reloaded once the previous word has left.
				if (out_free) begin
					cmd.load_y  = 1'b1;
					cmd.mul_sel = MUL_X_FF1;
					state_d     = ST_ADD_D2;
				end
			end
			ST_ADD_D2: begin
				cmd.acc_op  = ACC_PROD_D2;
				cmd.mul_sel = MUL_Y_FB1;
				state_d     = ST_SUB_FB1;
			end
			ST_SUB_FB1: begin
				cmd.acc_op  = ACC_SUB_PROD;
				cmd.mul_sel = MUL_X_FF2;
				state_d     = ST_SAVE_N1;
			end
			ST_SAVE_N1: begin
				cmd.wr_d1   = 1'b1;
				cmd.acc_op  = ACC_LOAD_PROD;
				cmd.mul_sel = MUL_Y_FB2;
				state_d     = ST_SUB_FB2;
			end
			ST_SUB_FB2: begin
				cmd.acc_op = ACC_SUB_PROD;
				cmd.wr_d2  = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			y_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_y)
				y_valid_q <= 1'b1;
			else if (y_ready)
				y_valid_q <= 1'b0;
		end
	end

	assign y_valid = y_valid_q;

endmodule

>>> design/biquad_df2t_filter.sv
// A sample word accepted while idle is multiplied, added to the first delay, rounded
// and loaded into the output register. A new sample is taken only back in idle, as
// the single shared multiplier forms all five products of a sample in turn.
// A waiting output word holds the next sample only at its output step.
// Reset (arst_n low, asynchronous) clears the coefficients, both delay registers,
// the controller state and the output valid flag.
// ----------------------------------------------------------------------------
// Biquad filter section, transposed direct form II
// Fixed-point second-order IIR with saturating accumulation and output.
// ----------------------------------------------------------------------------
module biquad_df2t_filter import bq_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          x_valid,
	output logic                          x_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          y_valid,
	input  logic                          y_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [COEF_BITS-1:0]          cfg_data
);

	cmd_t  cmd;
	coef_t coef;

	bq_coef_regs u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	bq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.x_valid (x_valid),
		.x_ready (x_ready),
		.y_valid (y_valid),
		.y_ready (y_ready),
		.cmd     (cmd)
	);

	bq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.coef       (coef),
		.sample_in  (sample_in),
		.sample_out (sample_out)
	);

`ifndef NO_ASSERTIONS
	// An accepted word occupies the datapath for the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(x_valid && x_ready) |=> !x_ready)
		else $error("input accepted again right after an accept");

	// The result register is never overwritten while a word still waits in it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_y |-> (!y_valid || y_ready))
		else $error("output overwritten before it was taken");

	// Writing the second delay is the last step; the block is idle right after.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_d2 |=> x_ready)
		else $error("controller not idle after the last delay update");

	// While idle the accumulator and delay registers are left alone.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		x_ready |-> (cmd.acc_op == ACC_HOLD && !cmd.wr_d1 && !cmd.wr_d2))
		else $error("datapath state changed while idle");
`endif

endmodule

>>> bench/biquad_out_checker.sv
// ----------------------------------------------------------------------------
// Biquad output checker
// Watches the sample, result and coefficient ports of the biquad section,
// runs its own fixed-point filter on every accepted sample word and compares
// each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module biquad_out_checker import bq_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          x_valid,
	input  logic                          x_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          y_valid,
	input  logic                          y_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [COEF_BITS-1:0]          cfg_data,
	output int                            errors,
	output int                            pending
);

	coef_t                         coefs;
	logic signed [DELAY_BITS-1:0]  delay_one;
	logic signed [DELAY_BITS-1:0]  delay_two;
	logic signed [SAMPLE_BITS-1:0] predicted_q[$];
	logic signed [SAMPLE_BITS-1:0] want;
	int                            bad_words;
	int                            words_out;

	// Addition that sticks at the 64-bit limits instead of wrapping.
	function automatic longint add_sat(input longint a, input longint b);
		logic signed [64:0] s;
		s = a;
		s = s + b;
		if (s[64] != s[63])
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
		return s[63:0];
	endfunction

	function automatic longint clamp_to(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// One filter step: output from the first delay, then both delays updated
	// from the input and the saturated output.
	function automatic logic signed [SAMPLE_BITS-1:0] filter_next(
		input logic signed [SAMPLE_BITS-1:0] x
	);
		longint xs;
		longint acc;
		longint yl;
		longint n1;
		longint n2;
		xs  = longint'(x);
		acc = add_sat(xs * longint'($signed(coefs.ff0)), longint'(delay_one));
		acc = add_sat(acc, longint'(1) << (OUT_SHIFT - 1));
		yl  = clamp_to(acc >>> OUT_SHIFT, SAMPLE_BITS);
		n1  = add_sat(xs * longint'($signed(coefs.ff1)), longint'(delay_two));
		n1  = add_sat(n1, -(longint'($signed(coefs.fb1)) * yl));
		n2  = add_sat(xs * longint'($signed(coefs.ff2)),
			-(longint'($signed(coefs.fb2)) * yl));
		delay_one = clamp_to(n1, DELAY_BITS);
		delay_two = clamp_to(n2, DELAY_BITS);
		return yl[SAMPLE_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs     = '0;
			delay_one = '0;
			delay_two = '0;
			predicted_q.delete();
			bad_words = 0;
			words_out = 0;
		end else begin
			if (y_valid && y_ready) begin
				if (predicted_q.size() == 0) begin
					if (bad_words < 10)
						$display("result word %0d arrived with no sample outstanding: %0d",
							words_out, sample_out);
					bad_words++;
				end else begin
					want = predicted_q.pop_front();
					if (sample_out !== want) begin
						if (bad_words < 10)
							$display("sample_out mismatch at word %0d: expected %0d, got %0d",
								words_out, want, sample_out);
						bad_words++;
					end
				end
				words_out++;
			end
			if (x_valid && x_ready)
				predicted_q.push_back(filter_next(sample_in));
			// Writes to indexes past the last register are dropped by the block.
			if (cfg_we) begin
				case (cfg_index)
					REG_FF_COEF0: coefs.ff0 = cfg_data;
					REG_FF_COEF1: coefs.ff1 = cfg_data;
					REG_FF_COEF2: coefs.ff2 = cfg_data;
					REG_FB_COEF1: coefs.fb1 = cfg_data;
					REG_FB_COEF2: coefs.fb2 = cfg_data;
					default: ;
				endcase
			end
		end
		errors  <= bad_words;
		pending <= predicted_q.size();
	end

endmodule

>>> bench/tb_biquad_df2t_filter.sv
// ----------------------------------------------------------------------------
// Biquad section testbench
// Drives sample words and coefficient sets into the biquad section under
// random idling on both channels, with a long result stall, and reports the
// verdict from the output checker.
// ----------------------------------------------------------------------------
module tb_biquad_df2t_filter import bq_pkg::*; ();

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	localparam logic [SAMPLE_BITS-1:0] S_MAX = 24'h7fffff;
	localparam logic [SAMPLE_BITS-1:0] S_MIN = 24'h800000;
	localparam logic [COEF_BITS-1:0]   C_MAX = 24'h7fffff;
	localparam logic [COEF_BITS-1:0]   C_MIN = 24'h800000;
	localparam logic [COEF_BITS-1:0]   C_ONE = 24'h100000;
	localparam logic [COEF_BITS-1:0]   C_NEG_ONE = 24'hf00000;
	localparam logic [COEF_BITS-1:0]   C_HALF = 24'h080000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          x_valid = 1'b0;
	logic                          x_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in = '0;
	logic                          y_valid;
	logic                          y_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
	logic [COEF_BITS-1:0]          cfg_data = '0;

	int mismatch_total;
	int outstanding;
	int send_idle_pct = 12;
	int recv_idle_pct = 81;
	int hold_count = 0;
	int stall_cycles = 0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;

	biquad_df2t_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.x_valid   (x_valid),
		.x_ready   (x_ready),
		.sample_in (sample_in),
		.y_valid   (y_valid),
		.y_ready   (y_ready),
		.sample_out(sample_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	biquad_out_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.x_valid   (x_valid),
		.x_ready   (x_ready),
		.sample_in (sample_in),
		.y_valid   (y_valid),
		.y_ready   (y_ready),
		.sample_out(sample_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (mismatch_total),
		.pending   (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: random backpressure, or a solid hold-off once requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_ready    <= 1'b0;
			hold_count <= 0;
			hold_done  <= 1'b0;
		end else if (hold_go && !hold_done) begin
			y_ready <= 1'b0;
			if (hold_count == HOLD_CYCLES - 1)
				hold_done <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			if (!hold_go) begin
				hold_count <= 0;
				hold_done  <= 1'b0;
			end
			y_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((x_valid && x_ready) || (y_valid && y_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_biquad_df2t_filter failed");
				$finish;
			end
		end
	end

	function automatic logic [COEF_BITS-1:0] pick_coef();
		case ($urandom_range(9))
			0, 1: begin
				case ($urandom_range(4))
					0: return C_MAX;
					1: return C_MIN;
					2: return '0;
					3: return C_ONE;
					default: return C_NEG_ONE;
				endcase
			end
			2, 3, 4: return COEF_BITS'($urandom());
			default: return COEF_BITS'(int'($urandom_range(2 << 20)) - (1 << 20));
		endcase
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return S_MAX;
					1: return S_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return SAMPLE_BITS'(int'($urandom_range(510)) - 255);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Valid is left high after acceptance, so a word that follows without a
	// gap never sees valid lowered and raised in one step.
	task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			x_valid <= 1'b0;
			@(posedge clk);
		end
		x_valid   <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (!x_ready)
			@(posedge clk);
	endtask

	task automatic settle();
		x_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_coefs(input coef_t c, input bit stray);
		logic [CFG_IDX_BITS-1:0] idx[5];
		logic [COEF_BITS-1:0]    val[5];
		idx = '{REG_FF_COEF0, REG_FF_COEF1, REG_FF_COEF2, REG_FB_COEF1, REG_FB_COEF2};
		val = '{c.ff0, c.ff1, c.ff2, c.fb1, c.fb2};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		// A write past the last register must leave every coefficient alone.
		if (stray) begin
			cfg_index <= REG_FB_COEF2 + CFG_IDX_BITS'($urandom_range(1, 3));
			cfg_data  <= COEF_BITS'($urandom());
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		coef_t c;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Coefficients straight out of reset are zero, so the output is zero.
		push_sample(S_MAX);
		push_sample(S_MIN);
		settle();

		c = '{ff0: C_ONE, ff1: '0, ff2: '0, fb1: '0, fb2: '0};
		write_coefs(c, 1'b0);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample('0);
		push_sample('1);
		push_sample(24'h000001);
		push_sample(24'h555555);
		push_sample(24'haaaaaa);
		settle();

		// Half gain puts odd samples exactly on the rounding tie.
		c = '{ff0: C_HALF, ff1: '0, ff2: '0, fb1: '0, fb2: '0};
		write_coefs(c, 1'b0);
		push_sample(24'h000001);
		push_sample('1);
		push_sample(24'h000003);
		push_sample(24'hfffffd);
		settle();

		// Extreme gains drive the output and both delays into saturation.
		c = '{ff0: C_MAX, ff1: C_MAX, ff2: C_MAX, fb1: C_MIN, fb2: C_MIN};
		write_coefs(c, 1'b1);
		push_sample(S_MAX);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample(S_MIN);
		push_sample('0);
		settle();

		c = '{ff0: C_MIN, ff1: C_MIN, ff2: C_MIN, fb1: C_MIN, fb2: C_MIN};
		write_coefs(c, 1'b1);
		push_sample(S_MIN);
		push_sample(S_MIN);
		push_sample(S_MAX);
		push_sample('0);

		for (int seg = 0; seg < 9; seg++) begin
			settle();
			if (seg == 3) begin
				send_idle_pct = 81;
				recv_idle_pct <= 12;
			end
			if (seg == 6) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			c.ff0 = pick_coef();
			c.ff1 = pick_coef();
			c.ff2 = pick_coef();
			c.fb1 = pick_coef();
			c.fb2 = pick_coef();
			write_coefs(c, 1'($urandom_range(1)));
			if (seg == 6) begin
				// Keep offering words while results are held back until the
				// block stops taking input.
				hold_go <= 1'b1;
				repeat (30) push_sample(pick_sample());
				while (!hold_done)
					@(posedge clk);
				hold_go <= 1'b0;
			end
			repeat (105) push_sample(pick_sample());
		end
		settle();

		if (mismatch_total == 0 && outstanding == 0)
			$display("tb_biquad_df2t_filter passed");
		else
			$display("tb_biquad_df2t_filter failed");
		$finish;
	end

endmodule
